### rtl/gtla_pkg.sv
// Types, constants and arithmetic helpers for the GPS track length accumulator.
`default_nettype none
package gtla_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CNT_W        = 6;
    localparam int MUL_STEPS    = 32;
    localparam int DIV_STEPS    = 32;
    localparam int SQRT_STEPS   = 32;

    localparam logic [15:0] RADIUS_RESET = 16'd6371;
    localparam int          CM_PER_KM    = 100000;

    localparam logic [31:0] PI_Q30_U      = 32'd3373259426;
    localparam logic signed [34:0] PI_Z        = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Z   = 35'sd1686629713;
    localparam logic signed [34:0] NEG_HALF_PI_Z = -35'sd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [31:0] DEG_DIVISOR = 32'd1800000000;
    localparam logic [63:0] DEG_HALF    = 64'd900000000;

    localparam logic [30:0] SEGMENT_MAX = 31'h7FFF_FFFF;
    localparam logic [39:0] TOTAL_MAX   = 40'hFF_FFFF_FFFF;
    localparam logic [31:0] TALLY_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [30:0] latitude;
        logic signed [31:0] longitude;
    } t_point;

    typedef struct packed {
        logic [30:0] segment_cm;
        logic [39:0] total_cm;
        logic [31:0] points_seen;
        logic        segment_valid;
    } t_result;

    // atan(2^-i) in Q30
    function automatic logic [29:0] atan_q30(input logic [CNT_W-1:0] i);
        logic [29:0] a;
        case (i)
            6'd0:  a = 30'd843314857;
            6'd1:  a = 30'd497837829;
            6'd2:  a = 30'd263043837;
            6'd3:  a = 30'd133525159;
            6'd4:  a = 30'd67021687;
            6'd5:  a = 30'd33543516;
            6'd6:  a = 30'd16775851;
            6'd7:  a = 30'd8388437;
            6'd8:  a = 30'd4194283;
            6'd9:  a = 30'd2097149;
            6'd10: a = 30'd1048576;
            6'd11: a = 30'd524288;
            6'd12: a = 30'd262144;
            6'd13: a = 30'd131072;
            6'd14: a = 30'd65536;
            6'd15: a = 30'd32768;
            6'd16: a = 30'd16384;
            6'd17: a = 30'd8192;
            6'd18: a = 30'd4096;
            6'd19: a = 30'd2048;
            6'd20: a = 30'd1024;
            6'd21: a = 30'd512;
            6'd22: a = 30'd256;
            6'd23: a = 30'd128;
            6'd24: a = 30'd64;
            6'd25: a = 30'd32;
            6'd26: a = 30'd16;
            6'd27: a = 30'd8;
            6'd28: a = 30'd4;
            6'd29: a = 30'd2;
            6'd30: a = 30'd1;
            6'd31: a = 30'd1;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

    // signed value from magnitude and sign, divided by 2^30, rounded half up
    function automatic logic signed [35:0] rnd30(input logic [64:0] mag, input logic neg);
        logic signed [66:0] v;
        v = $signed({2'b00, mag});
        if (neg) begin
            v = -v;
        end
        v = v + 67'sd536870912;
        v = v >>> 30;
        return v[35:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [33:0] v);
        logic signed [33:0] n;
        n = -v;
        return v[33] ? n[31:0] : v[31:0];
    endfunction

endpackage
`default_nettype wire

### rtl/gps_track_length_accumulator_top.sv
// GPS track length accumulator: bit-serial multiply, divide, CORDIC and square root.
// Work runs serially through the shared one-bit-per-cycle multiplier (ten products), two angle
// divisions, two CORDIC passes and the square root; the squares and square root are skipped
// for the first point or a saturated segment. One item in flight at a time: a new point is
// taken only after the previous result has been passed to the output.
// Reset (synchronous, active low) clears the previous point, tally and total, and sets
// the radius to 6371 km; a result held at the output is dropped.
`default_nettype none
module gps_track_length_accumulator_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire gtla_pkg::t_point  i_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output gtla_pkg::t_result      o_data,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [15:0]       i_cfg_data
);
    import gtla_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_ANG_MUL, S_ANG_DIV, S_CORDIC, S_PROD_MUL, S_DIFF, S_SQR_MUL, S_SQRT
    } t_state;
    typedef enum logic [2:0] {P_COSCOS, P_COSSIN, P_X, P_Y, P_Z} t_prod;
    typedef enum logic [1:0] {Q_X, Q_Y, Q_Z} t_sq;

    t_state r_state;
    logic   r_finish;
    logic   r_lon_pass;
    logic signed [31:0] r_lon;
    logic   r_aneg;
    logic [CNT_W-1:0] r_cnt;
    logic [32:0] r_ma;
    logic [31:0] r_mb;
    logic [64:0] r_acc;
    logic   r_mneg;
    logic [30:0] r_drem;
    logic [31:0] r_dq;
    logic signed [33:0] r_cx, r_cy;
    logic signed [34:0] r_cz;
    logic   r_flip;
    logic signed [33:0] r_clat, r_slat, r_clon, r_slon;
    t_prod  r_pidx;
    t_sq    r_sidx;
    logic signed [31:0] r_t1, r_t2;
    logic signed [31:0] r_x, r_y, r_z;
    logic signed [31:0] r_prev_x, r_prev_y, r_prev_z;
    logic [63:0] r_sum;
    logic [63:0] r_sn;
    logic [35:0] r_srem;
    logic [31:0] r_root;
    logic [30:0] r_seg;
    logic [31:0] r_tally;
    logic [39:0] r_total;
    logic [15:0] r_radius;
    t_result r_out;
    logic    r_out_valid;

    logic signed [32:0] w_lat_ext, w_lon_ext;
    logic [31:0] w_lat_mag, w_lon_mag;
    logic [64:0] w_acc_next;
    logic        w_mul_last;
    logic [63:0] w_dividend;
    logic [31:0] w_dtrial;
    logic        w_dge;
    logic [30:0] w_drem_next;
    logic [31:0] w_quot;
    logic signed [34:0] w_angle, w_zin;
    logic        w_flip;
    logic signed [33:0] w_cdx, w_cdy, w_cx_next, w_cy_next, w_cos, w_sin;
    logic signed [34:0] w_cz_next, w_atan;
    logic [32:0] w_rcm;
    t_prod       w_p_sel;
    logic [32:0] w_pa;
    logic [31:0] w_pb;
    logic        w_pneg;
    logic signed [35:0] w_rnd;
    logic signed [32:0] w_dx, w_dy, w_dz, w_ndx, w_ndy, w_ndz;
    logic [31:0] w_ax, w_ay, w_az;
    logic        w_sat;
    t_sq         w_s_sel;
    logic [31:0] w_sq;
    logic [35:0] w_srem_sh, w_strial, w_srem_next;
    logic [31:0] w_root_next;
    logic [32:0] w_seg_raw;
    logic [30:0] w_seg;
    logic [40:0] w_total_sum;
    logic [39:0] w_total_next;
    logic        w_seg_valid;

    always_comb begin
        w_lat_ext = {{2{i_data.latitude[30]}}, i_data.latitude};
        w_lat_mag = i_data.latitude[30] ? 32'(-w_lat_ext) : 32'(w_lat_ext);
        w_lon_ext = {r_lon[31], r_lon};
        w_lon_mag = r_lon[31] ? 32'(-w_lon_ext) : 32'(w_lon_ext);

        w_acc_next = {r_acc[63:0], 1'b0} + (r_mb[31] ? {32'd0, r_ma} : 65'd0);
        w_mul_last = (r_cnt == CNT_W'(MUL_STEPS - 1));
        w_dividend = w_acc_next[63:0] + DEG_HALF;

        w_dtrial    = {r_drem, r_dq[31]};
        w_dge       = (w_dtrial >= DEG_DIVISOR);
        w_drem_next = w_dge ? 31'(w_dtrial - DEG_DIVISOR) : w_dtrial[30:0];
        w_quot      = {r_dq[30:0], w_dge};
        w_angle     = r_aneg ? -$signed({3'b000, w_quot}) : $signed({3'b000, w_quot});
        w_flip      = 1'b0;
        w_zin       = w_angle;
        if (w_angle > HALF_PI_Z) begin
            w_zin  = w_angle - PI_Z;
            w_flip = 1'b1;
        end else if (w_angle < NEG_HALF_PI_Z) begin
            w_zin  = w_angle + PI_Z;
            w_flip = 1'b1;
        end

        w_cdx  = r_cy >>> r_cnt;
        w_cdy  = r_cx >>> r_cnt;
        w_atan = $signed({5'b00000, atan_q30(r_cnt)});
        if (!r_cz[34]) begin
            w_cx_next = r_cx - w_cdx;
            w_cy_next = r_cy + w_cdy;
            w_cz_next = r_cz - w_atan;
        end else begin
            w_cx_next = r_cx + w_cdx;
            w_cy_next = r_cy - w_cdy;
            w_cz_next = r_cz + w_atan;
        end
        w_cos = r_flip ? -w_cx_next : w_cx_next;
        w_sin = r_flip ? -w_cy_next : w_cy_next;

        w_rcm = 33'(r_radius) * 33'(CM_PER_KM);
        w_p_sel = P_COSCOS;
        if (r_state == S_PROD_MUL) begin
            case (r_pidx)
                P_COSCOS: w_p_sel = P_COSSIN;
                P_COSSIN: w_p_sel = P_X;
                P_X:      w_p_sel = P_Y;
                P_Y:      w_p_sel = P_Z;
                default:  w_p_sel = P_COSCOS;
            endcase
        end
        case (w_p_sel)
            P_COSCOS: begin
                w_pa   = {1'b0, mag32(r_clat)};
                w_pb   = mag32(r_clon);
                w_pneg = r_clat[33] ^ r_clon[33];
            end
            P_COSSIN: begin
                w_pa   = {1'b0, mag32(r_clat)};
                w_pb   = mag32(r_slon);
                w_pneg = r_clat[33] ^ r_slon[33];
            end
            P_X: begin
                w_pa   = w_rcm;
                w_pb   = mag32({{2{r_t1[31]}}, r_t1});
                w_pneg = r_t1[31];
            end
            P_Y: begin
                w_pa   = w_rcm;
                w_pb   = mag32({{2{r_t2[31]}}, r_t2});
                w_pneg = r_t2[31];
            end
            default: begin
                w_pa   = w_rcm;
                w_pb   = mag32(r_slat);
                w_pneg = r_slat[33];
            end
        endcase
        w_rnd = rnd30(w_acc_next, r_mneg);

        w_dx  = {r_x[31], r_x} - {r_prev_x[31], r_prev_x};
        w_dy  = {r_y[31], r_y} - {r_prev_y[31], r_prev_y};
        w_dz  = {r_z[31], r_z} - {r_prev_z[31], r_prev_z};
        w_ndx = -w_dx;
        w_ndy = -w_dy;
        w_ndz = -w_dz;
        w_ax  = w_dx[32] ? w_ndx[31:0] : w_dx[31:0];
        w_ay  = w_dy[32] ? w_ndy[31:0] : w_dy[31:0];
        w_az  = w_dz[32] ? w_ndz[31:0] : w_dz[31:0];
        w_sat = w_ax[31] | w_ay[31] | w_az[31];

        w_s_sel = Q_X;
        if (r_state == S_SQR_MUL) begin
            case (r_sidx)
                Q_X:     w_s_sel = Q_Y;
                default: w_s_sel = Q_Z;
            endcase
        end
        case (w_s_sel)
            Q_X:     w_sq = w_ax;
            Q_Y:     w_sq = w_ay;
            default: w_sq = w_az;
        endcase

        w_srem_sh = {r_srem[33:0], r_sn[63:62]};
        w_strial  = {2'b00, r_root, 2'b01};
        if (w_srem_sh >= w_strial) begin
            w_srem_next = w_srem_sh - w_strial;
            w_root_next = {r_root[30:0], 1'b1};
        end else begin
            w_srem_next = w_srem_sh;
            w_root_next = {r_root[30:0], 1'b0};
        end
        w_seg_raw = (w_srem_next > {4'd0, w_root_next}) ? {1'b0, w_root_next} + 33'd1
                                                         : {1'b0, w_root_next};
        w_seg = (w_seg_raw > {2'b00, SEGMENT_MAX}) ? SEGMENT_MAX : w_seg_raw[30:0];

        w_seg_valid  = (r_tally != 32'd0);
        w_total_sum  = {1'b0, r_total} + {10'd0, r_seg};
        w_total_next = r_total;
        if (w_seg_valid) begin
            w_total_next = w_total_sum[40] ? TOTAL_MAX : w_total_sum[39:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_finish    <= 1'b0;
            r_out_valid <= 1'b0;
            r_radius    <= RADIUS_RESET;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_z    <= '0;
            r_tally     <= '0;
            r_total     <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_radius <= i_cfg_data;
            end
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (r_finish) begin
                        if (!r_out_valid || !i_stall) begin
                            r_out.segment_cm    <= r_seg;
                            r_out.total_cm      <= w_total_next;
                            r_out.points_seen   <= (r_tally != TALLY_MAX) ? r_tally + 32'd1
                                                                          : r_tally;
                            r_out.segment_valid <= w_seg_valid;
                            r_out_valid         <= 1'b1;
                            r_total             <= w_total_next;
                            r_tally             <= (r_tally != TALLY_MAX) ? r_tally + 32'd1
                                                                          : r_tally;
                            r_prev_x            <= r_x;
                            r_prev_y            <= r_y;
                            r_prev_z            <= r_z;
                            r_finish            <= 1'b0;
                        end
                    end else if (i_valid) begin
                        r_lon      <= i_data.longitude;
                        r_aneg     <= i_data.latitude[30];
                        r_lon_pass <= 1'b0;
                        r_ma       <= {1'b0, w_lat_mag};
                        r_mb       <= PI_Q30_U;
                        r_acc      <= '0;
                        r_cnt      <= '0;
                        r_state    <= S_ANG_MUL;
                    end
                end
                S_ANG_MUL: begin
                    r_acc <= w_acc_next;
                    r_mb  <= {r_mb[30:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (w_mul_last) begin
                        r_drem  <= w_dividend[62:32];
                        r_dq    <= w_dividend[31:0];
                        r_cnt   <= '0;
                        r_state <= S_ANG_DIV;
                    end
                end
                S_ANG_DIV: begin
                    r_drem <= w_drem_next;
                    r_dq   <= w_quot;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_cx    <= CORDIC_GAIN;
                        r_cy    <= '0;
                        r_cz    <= w_zin;
                        r_flip  <= w_flip;
                        r_cnt   <= '0;
                        r_state <= S_CORDIC;
                    end
                end
                S_CORDIC: begin
                    r_cx  <= w_cx_next;
                    r_cy  <= w_cy_next;
                    r_cz  <= w_cz_next;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                        r_cnt <= '0;
                        r_acc <= '0;
                        if (!r_lon_pass) begin
                            r_clat     <= w_cos;
                            r_slat     <= w_sin;
                            r_lon_pass <= 1'b1;
                            r_aneg     <= r_lon[31];
                            r_ma       <= {1'b0, w_lon_mag};
                            r_mb       <= PI_Q30_U;
                            r_state    <= S_ANG_MUL;
                        end else begin
                            r_clon  <= w_cos;
                            r_slon  <= w_sin;
                            r_pidx  <= P_COSCOS;
                            r_ma    <= {1'b0, mag32(r_clat)};
                            r_mb    <= mag32(w_cos);
                            r_mneg  <= r_clat[33] ^ w_cos[33];
                            r_state <= S_PROD_MUL;
                        end
                    end
                end
                S_PROD_MUL: begin
                    r_acc <= w_acc_next;
                    r_mb  <= {r_mb[30:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (w_mul_last) begin
                        case (r_pidx)
                            P_COSCOS: r_t1 <= w_rnd[31:0];
                            P_COSSIN: r_t2 <= w_rnd[31:0];
                            P_X:      r_x  <= sat32(w_rnd);
                            P_Y:      r_y  <= sat32(w_rnd);
                            default:  r_z  <= sat32(w_rnd);
                        endcase
                        r_cnt  <= '0;
                        r_acc  <= '0;
                        r_pidx <= w_p_sel;
                        r_ma   <= w_pa;
                        r_mb   <= w_pb;
                        r_mneg <= w_pneg;
                        if (r_pidx == P_Z) begin
                            r_state <= S_DIFF;
                        end
                    end
                end
                S_DIFF: begin
                    r_sum <= '0;
                    r_acc <= '0;
                    r_cnt <= '0;
                    if (!w_seg_valid) begin
                        r_seg    <= '0;
                        r_finish <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (w_sat) begin
                        r_seg    <= SEGMENT_MAX;
                        r_finish <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_sidx  <= w_s_sel;
                        r_ma    <= {1'b0, w_sq};
                        r_mb    <= w_sq;
                        r_state <= S_SQR_MUL;
                    end
                end
                S_SQR_MUL: begin
                    r_acc <= w_acc_next;
                    r_mb  <= {r_mb[30:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (w_mul_last) begin
                        r_cnt <= '0;
                        r_acc <= '0;
                        if (r_sidx == Q_Z) begin
                            r_sn    <= r_sum + w_acc_next[63:0];
                            r_srem  <= '0;
                            r_root  <= '0;
                            r_state <= S_SQRT;
                        end else begin
                            r_sum  <= r_sum + w_acc_next[63:0];
                            r_sidx <= w_s_sel;
                            r_ma   <= {1'b0, w_sq};
                            r_mb   <= w_sq;
                        end
                    end
                end
                S_SQRT: begin
                    r_srem <= w_srem_next;
                    r_root <= w_root_next;
                    r_sn   <= {r_sn[61:0], 2'b00};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                        r_seg    <= w_seg;
                        r_finish <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall     = (r_state != S_IDLE) || r_finish;
    assign o_cfg_ready = (r_state == S_IDLE) && !r_finish;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block took an item but did not go busy");
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.points_seen != 32'd0))
        else $error("result shows a zero point count");
    a_first_point_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.segment_valid) |-> (o_data.segment_cm == 31'd0))
        else $error("segment without a previous point is not zero");
    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_total >= $past(r_total)))
        else $error("running total decreased");
`endif

endmodule
`default_nettype wire
